// ===== rtl/core/rbpb_pkg.sv =====
// Shared types and constants for the radial brush pixel blend pipeline.
// Used by rbpb_sqrt, rbpb_div and radial_brush_pixel_blend_unit.
package rbpb_pkg;

	localparam int unsigned COORD_BITS = 12;

	localparam logic [13:0] MAP_LIM    = 14'(1 << COORD_BITS);
	localparam logic [11:0] COORD_MASK = 12'((1 << COORD_BITS) - 1);

	localparam int unsigned D2_W       = 30;
	localparam int unsigned ROOT_W     = 31;
	localparam int unsigned REM_W      = 34;
	localparam int unsigned SQRT_STEPS = ROOT_W;

	localparam int unsigned Q_W        = 16;
	localparam int unsigned DIV_FRAC   = 8;
	localparam int unsigned DIV_STEPS  = Q_W;

	localparam int unsigned PIPE_LATENCY = 3 + SQRT_STEPS + 1 + DIV_STEPS + 2;

	localparam logic [16:0] ONE_Q16    = 17'h10000;
	localparam logic [15:0] RADIUS_MIN = 16'd128;

	localparam logic [15:0] RADIUS_RST = 16'd256;
	localparam logic [15:0] RATE_RST   = 16'd0;
	localparam logic [12:0] MAP_RST    = 13'd4096;

	typedef enum logic [2:0] {
		REG_BRUSH_RADIUS = 3'd0,
		REG_RATE_FACTOR  = 3'd1,
		REG_MATERIAL     = 3'd2,
		REG_MAP_WIDTH    = 3'd3,
		REG_MAP_HEIGHT   = 3'd4
	} cfg_reg_t;

	typedef enum logic [1:0] {
		MAT_BLACK = 2'd0,
		MAT_BLUE  = 2'd1,
		MAT_GREEN = 2'd2
	} mat_t;

	typedef struct packed {
		logic        on_map;
		logic [11:0] px;
		logic [11:0] py;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
	} meta_t;

endpackage

// ===== rtl/core/rbpb_sqrt.sv =====
// Pipelined integer square root, one result bit per stage, of d2 * 2^32.
// Depends on rbpb_pkg for widths and the pixel side-band type.
module rbpb_sqrt (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_vld,
	input  logic [rbpb_pkg::D2_W-1:0]    in_d2,
	input  rbpb_pkg::meta_t              in_meta,
	output logic                         out_vld,
	output logic [rbpb_pkg::ROOT_W-1:0]  out_root,
	output rbpb_pkg::meta_t              out_meta
);

	localparam int unsigned N = rbpb_pkg::SQRT_STEPS;

	logic                             vld_s  [0:N];
	logic [rbpb_pkg::ROOT_W-1:0]      root_s [0:N];
	rbpb_pkg::meta_t                  meta_s [0:N];
	logic [rbpb_pkg::REM_W-1:0]       rem_s  [0:N-1];
	logic [rbpb_pkg::D2_W-1:0]        d2_s   [0:N-1];

	assign vld_s[0]  = in_vld;
	assign root_s[0] = '0;
	assign meta_s[0] = in_meta;
	assign rem_s[0]  = '0;
	assign d2_s[0]   = in_d2;

	for (genvar k = 0; k < N; k++) begin : g_step
		logic [rbpb_pkg::REM_W-1:0] rem_x;
		logic [rbpb_pkg::REM_W-1:0] trial;
		logic                       take;

		assign rem_x = {rem_s[k][rbpb_pkg::REM_W-3:0], d2_s[k][rbpb_pkg::D2_W-1 -: 2]};
		assign trial = {1'b0, root_s[k], 2'b01};
		assign take  = rem_x >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			root_s[k+1] <= {root_s[k][rbpb_pkg::ROOT_W-2:0], take};
			meta_s[k+1] <= meta_s[k];
		end

		if (k < N - 1) begin : g_carry
			always_ff @(posedge clk) begin
				rem_s[k+1] <= take ? (rem_x - trial) : rem_x;
				d2_s[k+1]  <= {d2_s[k][rbpb_pkg::D2_W-3:0], 2'b00};
			end
		end
	end

	assign out_vld  = vld_s[N];
	assign out_root = root_s[N];
	assign out_meta = meta_s[N];

endmodule

// ===== rtl/core/rbpb_div.sv =====
// Pipelined restoring divider: q = (s << 8) / radius, one quotient bit per stage.
// Flags quotients of one or more; depends on rbpb_pkg.
module rbpb_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_vld,
	input  logic [rbpb_pkg::ROOT_W-1:0]  in_s,
	input  logic [15:0]                  radius,
	input  rbpb_pkg::meta_t              in_meta,
	output logic                         out_vld,
	output logic [rbpb_pkg::Q_W-1:0]     out_q,
	output logic                         out_over,
	output rbpb_pkg::meta_t              out_meta
);

	localparam int unsigned N  = rbpb_pkg::DIV_STEPS;
	localparam int unsigned QW = rbpb_pkg::Q_W;
	localparam int unsigned FR = rbpb_pkg::DIV_FRAC;

	logic              vld_s  [0:N];
	logic              over_s [0:N];
	logic [QW-1:0]     q_s    [0:N];
	rbpb_pkg::meta_t   meta_s [0:N];
	logic [15:0]       rem_s  [0:N-1];
	logic [QW-1:0]     bits_s [0:N-1];

	logic over;

	assign over   = in_s >= rbpb_pkg::ROOT_W'({radius, FR'(0)});
	assign q_s[0] = '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else begin
			vld_s[0] <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		over_s[0] <= over;
		meta_s[0] <= in_meta;
		rem_s[0]  <= in_s[QW+FR-1:FR];
		bits_s[0] <= {in_s[FR-1:0], (QW-FR)'(0)};
	end

	for (genvar k = 0; k < N; k++) begin : g_step
		logic [16:0] rem_x;
		logic        take;

		assign rem_x = {rem_s[k], bits_s[k][QW-1]};
		assign take  = rem_x >= {1'b0, radius};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			q_s[k+1]    <= {q_s[k][QW-2:0], take};
			over_s[k+1] <= over_s[k];
			meta_s[k+1] <= meta_s[k];
		end

		if (k < N - 1) begin : g_carry
			always_ff @(posedge clk) begin
				rem_s[k+1]  <= take ? 16'(rem_x - {1'b0, radius}) : rem_x[15:0];
				bits_s[k+1] <= {bits_s[k][QW-2:0], 1'b0};
			end
		end
	end

	assign out_vld  = vld_s[N];
	assign out_q    = q_s[N];
	assign out_over = over_s[N];
	assign out_meta = meta_s[N];

`ifndef NO_ASSERTIONS
	a_rem_below_radius: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[0] && !over_s[0] |-> rem_s[0] < radius)
		else $error("divider start remainder not below radius");
`endif

endmodule

// ===== rtl/core/radial_brush_pixel_blend_unit.sv =====
// Radial brush pixel blend: on-map test, distance, falloff weight, RGB blend.
// Depends on rbpb_pkg, rbpb_sqrt and rbpb_div.
// An accepted request passes stages s1 to s3, the square root and divider stages, then s52 and s53; done is vld_s53.
// Throughput one request per cycle; busy stays low, the square root and divider stages set depth.
// arst_n clears the stage valid bits and loads the register reset values.
module radial_brush_pixel_blend_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [13:0] center_x,
	input  logic signed [13:0] center_y,
	input  logic signed [13:0] pixel_x,
	input  logic signed [13:0] pixel_y,
	input  logic [7:0]         old_red,
	input  logic [7:0]         old_green,
	input  logic [7:0]         old_blue,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	output logic               done,
	output logic               write_enable,
	output logic [11:0]        out_x,
	output logic [11:0]        out_y,
	output logic [7:0]         new_red,
	output logic [7:0]         new_green,
	output logic [7:0]         new_blue,
	output logic [7:0]         new_alpha
);

	localparam int unsigned LATENCY = rbpb_pkg::PIPE_LATENCY;

	logic [15:0] brush_radius_q;
	logic [15:0] rate_factor_q;
	logic [1:0]  material_q;
	logic [12:0] map_width_q;
	logic [12:0] map_height_q;

	logic [13:0] mw_eff;
	logic [13:0] mh_eff;
	logic [15:0] radius_eff;
	logic        tgt_blue;
	logic        tgt_green;

	logic                  accept;
	logic signed [14:0]    dx;
	logic signed [14:0]    dy;
	logic                  on_map;
	rbpb_pkg::meta_t       meta_in;

	logic                  vld_s1;
	logic [13:0]           adx_s1;
	logic [13:0]           ady_s1;
	rbpb_pkg::meta_t       meta_s1;

	logic                  vld_s2;
	logic [27:0]           sqx_s2;
	logic [27:0]           sqy_s2;
	rbpb_pkg::meta_t       meta_s2;

	logic                  vld_s3;
	logic [rbpb_pkg::D2_W-1:0] d2_s3;
	rbpb_pkg::meta_t       meta_s3;

	logic                          sq_vld;
	logic [rbpb_pkg::ROOT_W-1:0]   sq_root;
	rbpb_pkg::meta_t               sq_meta;

	logic                          dv_vld;
	logic [rbpb_pkg::Q_W-1:0]      dv_q;
	logic                          dv_over;
	rbpb_pkg::meta_t               dv_meta;

	logic [16:0]           inv_q;
	logic [32:0]           w_prod;
	logic [15:0]           w_raw;

	logic                  vld_s52;
	logic                  we_s52;
	logic [15:0]           w_s52;
	rbpb_pkg::meta_t       meta_s52;

	logic [16:0]           iw;

	logic                  vld_s53;
	logic                  we_s53;
	logic [11:0]           x_s53;
	logic [11:0]           y_s53;
	logic [7:0]            red_s53;
	logic [7:0]            green_s53;
	logic [7:0]            blue_s53;

	function automatic logic [7:0] blend_ch(logic tgt, logic [7:0] old_c, logic [15:0] w,
			logic [16:0] inv_w);
		logic [24:0] tw;
		logic [24:0] acc;
		tw  = tgt ? ({1'b0, w, 8'h00} - {9'h000, w}) : 25'd0;
		acc = tw + 25'(old_c) * 25'(inv_w);
		return acc[23:16];
	endfunction

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			brush_radius_q <= rbpb_pkg::RADIUS_RST;
			rate_factor_q  <= rbpb_pkg::RATE_RST;
			material_q     <= rbpb_pkg::MAT_BLACK;
			map_width_q    <= rbpb_pkg::MAP_RST;
			map_height_q   <= rbpb_pkg::MAP_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (rbpb_pkg::cfg_reg_t'(cfg_index))
				rbpb_pkg::REG_BRUSH_RADIUS: brush_radius_q <= cfg_data;
				rbpb_pkg::REG_RATE_FACTOR:  rate_factor_q  <= cfg_data;
				rbpb_pkg::REG_MATERIAL:     material_q     <= cfg_data[1:0];
				rbpb_pkg::REG_MAP_WIDTH:    map_width_q    <= cfg_data[12:0];
				rbpb_pkg::REG_MAP_HEIGHT:   map_height_q   <= cfg_data[12:0];
				default: ;
			endcase
		end
	end

	assign mw_eff = ({1'b0, map_width_q} > rbpb_pkg::MAP_LIM) ? rbpb_pkg::MAP_LIM
		: {1'b0, map_width_q};
	assign mh_eff = ({1'b0, map_height_q} > rbpb_pkg::MAP_LIM) ? rbpb_pkg::MAP_LIM
		: {1'b0, map_height_q};
	assign radius_eff = (brush_radius_q < rbpb_pkg::RADIUS_MIN) ? rbpb_pkg::RADIUS_MIN
		: brush_radius_q;

	always_comb begin
		tgt_blue  = 1'b0;
		tgt_green = 1'b0;
		unique case (rbpb_pkg::mat_t'(material_q))
			rbpb_pkg::MAT_BLUE:  tgt_blue  = 1'b1;
			rbpb_pkg::MAT_GREEN: tgt_green = 1'b1;
			default: ;
		endcase
	end

	assign dx = {pixel_x[13], pixel_x} - {center_x[13], center_x};
	assign dy = {pixel_y[13], pixel_y} - {center_y[13], center_y};

	assign on_map = !pixel_x[13] && !pixel_y[13]
		&& ($unsigned(pixel_x) < mw_eff) && ($unsigned(pixel_y) < mh_eff);

	always_comb begin
		meta_in.on_map = on_map;
		meta_in.px     = pixel_x[11:0] & rbpb_pkg::COORD_MASK;
		meta_in.py     = pixel_y[11:0] & rbpb_pkg::COORD_MASK;
		meta_in.red    = old_red;
		meta_in.green  = old_green;
		meta_in.blue   = old_blue;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= accept;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		adx_s1  <= dx[14] ? 14'(-dx) : dx[13:0];
		ady_s1  <= dy[14] ? 14'(-dy) : dy[13:0];
		meta_s1 <= meta_in;
		sqx_s2  <= 28'(adx_s1) * 28'(adx_s1);
		sqy_s2  <= 28'(ady_s1) * 28'(ady_s1);
		meta_s2 <= meta_s1;
		d2_s3   <= {2'b00, sqx_s2} + {2'b00, sqy_s2};
		meta_s3 <= meta_s2;
	end

	rbpb_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (vld_s3),
		.in_d2    (d2_s3),
		.in_meta  (meta_s3),
		.out_vld  (sq_vld),
		.out_root (sq_root),
		.out_meta (sq_meta)
	);

	rbpb_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (sq_vld),
		.in_s     (sq_root),
		.radius   (radius_eff),
		.in_meta  (sq_meta),
		.out_vld  (dv_vld),
		.out_q    (dv_q),
		.out_over (dv_over),
		.out_meta (dv_meta)
	);

	assign inv_q  = rbpb_pkg::ONE_Q16 - {1'b0, dv_q};
	assign w_prod = 33'(inv_q) * 33'(rate_factor_q);
	assign w_raw  = w_prod[31:16];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s52 <= 1'b0;
			vld_s53 <= 1'b0;
		end else begin
			vld_s52 <= dv_vld;
			vld_s53 <= vld_s52;
		end
	end

	always_ff @(posedge clk) begin
		we_s52   <= dv_meta.on_map && !dv_over && (w_raw != 16'd0);
		w_s52    <= w_raw;
		meta_s52 <= dv_meta;
	end

	assign iw = rbpb_pkg::ONE_Q16 - {1'b0, w_s52};

	always_ff @(posedge clk) begin
		we_s53 <= we_s52;
		if (we_s52) begin
			x_s53     <= meta_s52.px;
			y_s53     <= meta_s52.py;
			red_s53   <= blend_ch(1'b0, meta_s52.red, w_s52, iw);
			green_s53 <= blend_ch(tgt_green, meta_s52.green, w_s52, iw);
			blue_s53  <= blend_ch(tgt_blue, meta_s52.blue, w_s52, iw);
		end else begin
			x_s53     <= '0;
			y_s53     <= '0;
			red_s53   <= '0;
			green_s53 <= '0;
			blue_s53  <= '0;
		end
	end

	assign done         = vld_s53;
	assign write_enable = we_s53;
	assign out_x        = x_s53;
	assign out_y        = y_s53;
	assign new_red      = red_s53;
	assign new_green    = green_s53;
	assign new_blue     = blue_s53;
	assign new_alpha    = 8'hFF;

`ifndef NO_ASSERTIONS
	a_request_done: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##LATENCY done)
		else $error("request without result at pipeline depth");

	a_no_write_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !write_enable |-> out_x == 12'd0 && out_y == 12'd0 && new_red == 8'd0
			&& new_green == 8'd0 && new_blue == 8'd0)
		else $error("result fields not cleared without write");

	a_write_on_map: assert property (@(posedge clk) disable iff (!arst_n)
		done && write_enable |-> {2'b00, out_x} < mw_eff && {2'b00, out_y} < mh_eff)
		else $error("write outside map bounds");
`endif

endmodule
